// ----- sv/csm_pkg.sv -----
package csm_pkg;

  localparam int DATA_W   = 16;
  localparam int ACC_W    = 48;
  // |dot| * 16384 fits here for any vector length up to 65536
  localparam int MAG_W    = ACC_W - 1 + 14;
  localparam int PROD_W   = 2 * MAG_W;
  localparam int U_W      = 15;
  localparam int SIM_W    = 16;
  localparam logic [U_W-1:0]   HALF_U     = 15'd16384;
  localparam logic [SIM_W-1:0] HALF_SIM   = 16'd16384;
  localparam logic [SIM_W-1:0] THR_RESET  = 16'd27853;

  typedef enum logic [1:0] {
    MAC_DOT,
    MAC_NA,
    MAC_NB
  } mac_sel_e;

  typedef struct packed {
    logic     en;
    logic     clr;
    mac_sel_e sel;
  } mac_ctrl_t;

endpackage

// ----- sv/csm_if.sv -----
interface csm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [csm_pkg::DATA_W-1:0]   elem_a;
  logic signed [csm_pkg::DATA_W-1:0]   elem_b;
  logic                                last_pair;

  modport source (output valid, output elem_a, output elem_b, output last_pair, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last_pair, output ready);
endinterface

interface csm_out_if;
  logic                         valid;
  logic                         ready;
  logic [csm_pkg::SIM_W-1:0]    similarity;
  logic                         is_match;
  logic                         degenerate;

  modport source (output valid, output similarity, output is_match, output degenerate,
                  input ready);
  modport sink   (input valid, input similarity, input is_match, input degenerate,
                  output ready);
endinterface

// ----- sv/csm_mac.sv -----
module csm_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csm_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [csm_pkg::DATA_W-1:0]   a_i,
  input  logic signed [csm_pkg::DATA_W-1:0]   b_i,
  output logic signed [csm_pkg::ACC_W-1:0]    dot_o,
  output logic        [csm_pkg::ACC_W-1:0]    na_o,
  output logic        [csm_pkg::ACC_W-1:0]    nb_o
);
  import csm_pkg::*;

  logic signed [DATA_W-1:0]   op_x, op_y;
  logic signed [2*DATA_W-1:0] prod;
  logic signed [ACC_W-1:0]    prod_ext;
  logic signed [ACC_W-1:0]    dot_q;
  logic        [ACC_W-1:0]    na_q, nb_q;

  // one multiplier shared by the three products of a pair
  always_comb begin
    unique case (ctrl_i.sel)
      MAC_DOT: begin op_x = a_i; op_y = b_i; end
      MAC_NA:  begin op_x = a_i; op_y = a_i; end
      MAC_NB:  begin op_x = b_i; op_y = b_i; end
      default: begin op_x = a_i; op_y = b_i; end
    endcase
  end

  assign prod     = op_x * op_y;
  assign prod_ext = ACC_W'(prod);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (ctrl_i.clr) begin
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
    end else if (ctrl_i.en) begin
      case (ctrl_i.sel)
        MAC_DOT: dot_q <= dot_q + prod_ext;
        MAC_NA:  na_q  <= na_q + unsigned'(prod_ext);
        MAC_NB:  nb_q  <= nb_q + unsigned'(prod_ext);
        default: ;
      endcase
    end
  end

  assign dot_o = dot_q;
  assign na_o  = na_q;
  assign nb_o  = nb_q;
endmodule

// ----- sv/csm_mul.sv -----
module csm_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [csm_pkg::PROD_W-1:0]    x_i,
  input  logic [csm_pkg::MAG_W-1:0]     y_i,
  output logic                          done_o,
  output logic [csm_pkg::PROD_W-1:0]    p_o
);
  import csm_pkg::*;

  logic              running_q;
  logic [PROD_W-1:0] xs_q, acc_q;
  logic [MAG_W-1:0]  ys_q;

  // shift-add, one multiplier bit per cycle, stops once the rest is zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
    end else if (start_i) begin
      running_q <= 1'b1;
    end else if (running_q && ys_q == '0) begin
      running_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      xs_q  <= x_i;
      ys_q  <= y_i;
    end else if (running_q && ys_q != '0) begin
      if (ys_q[0]) acc_q <= acc_q + xs_q;
      xs_q <= xs_q << 1;
      ys_q <= ys_q >> 1;
    end
  end

  assign done_o = running_q && ys_q == '0;
  assign p_o    = acc_q;
endmodule

// ----- sv/cosine_similarity_match.sv -----
// channel  | dir | payload                              | transaction
// pipe_i   | in  | elem_a, elem_b, last_pair            | valid & ready
// result_o | out | similarity, is_match, degenerate     | valid & ready
// cfg      | in  | cfg_wdata_i (match_threshold)        | cfg_we_i
//
// each element pair within MAX_LEN: one 16x16 multiplier produces dot, a*a, b*b in turn
// a last pair with nonzero norms adds the final phase on a shift-add multiplier, one bit per cycle:
// |dot|^2 and norm product, then a 15-step binary search, each step a square and a product
// reset clears the accumulators, the pair count and loads the threshold with 27853
// a waiting result stalls only the next last pair; other pairs keep flowing
module cosine_similarity_match #(
  parameter int MAX_LEN = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  csm_in_if.sink                     pipe_i,
  csm_out_if.source                  result_o,
  input  logic                       cfg_we_i,
  input  logic [csm_pkg::SIM_W-1:0]  cfg_wdata_i
);
  import csm_pkg::*;

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_DOT, S_NA, S_NB, S_CHK, S_D2, S_N, S_SRCH, S_SQ, S_CMP, S_RES
  } state_e;

  state_e               state_q;
  logic [SIM_W-1:0]     thr_q;
  logic [CNT_W-1:0]     cnt_q;
  logic signed [DATA_W-1:0] a_q, b_q;
  logic                 last_q;
  mac_ctrl_t            mac_ctrl;
  logic                 mac_clr_q;
  logic signed [ACC_W-1:0] dot;
  logic [ACC_W-1:0]     na, nb, mag;
  logic                 dneg_q;
  logic                 mul_start_q, mul_done;
  logic [PROD_W-1:0]    mul_x_q, mul_p;
  logic [MAG_W-1:0]     mul_y_q;
  logic [PROD_W-1:0]    d2_q, n_q;
  logic [U_W-1:0]       lo_q, hi_q, mid_q;
  logic [U_W:0]         mid_sum;
  logic [SIM_W-1:0]     res_sim_q;
  logic                 res_match_q, res_degen_q;
  logic                 out_valid_q;
  logic [SIM_W-1:0]     out_sim_q;
  logic                 out_match_q, out_degen_q;
  logic                 in_fire, out_free;
  logic [SIM_W-1:0]     sim_fin;

  always_comb begin
    mac_ctrl.clr = mac_clr_q;
    mac_ctrl.en  = state_q == S_DOT || state_q == S_NA || state_q == S_NB;
    unique case (state_q)
      S_NA:    mac_ctrl.sel = MAC_NA;
      S_NB:    mac_ctrl.sel = MAC_NB;
      default: mac_ctrl.sel = MAC_DOT;
    endcase
  end

  csm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (a_q),
    .b_i    (b_q),
    .dot_o  (dot),
    .na_o   (na),
    .nb_o   (nb)
  );

  csm_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start_q),
    .x_i     (mul_x_q),
    .y_i     (mul_y_q),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  assign in_fire  = pipe_i.valid && pipe_i.ready;
  assign out_free = !out_valid_q || result_o.ready;
  assign mag      = dot[ACC_W-1] ? ACC_W'(-dot) : ACC_W'(dot);
  // negative dot searches the smallest u, positive the largest
  assign mid_sum  = dneg_q ? ({1'b0, lo_q} + {1'b0, hi_q})
                           : ({1'b0, lo_q} + {1'b0, hi_q} + (U_W+1)'(1));
  assign sim_fin  = dneg_q ? HALF_SIM - SIM_W'(lo_q) : HALF_SIM + SIM_W'(lo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      mac_clr_q   <= 1'b0;
      mul_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      mac_clr_q   <= 1'b0;
      mul_start_q <= 1'b0;
      if (out_valid_q && result_o.ready) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            a_q    <= pipe_i.elem_a;
            b_q    <= pipe_i.elem_b;
            last_q <= pipe_i.last_pair;
            state_q <= (cnt_q < CNT_W'(MAX_LEN)) ? S_DOT : S_CHK;
          end
        end
        S_DOT: state_q <= S_NA;
        S_NA:  state_q <= S_NB;
        S_NB: begin
          cnt_q   <= cnt_q + CNT_W'(1);
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (!last_q) begin
            state_q <= S_IDLE;
          end else if (na == '0 || nb == '0) begin
            res_sim_q   <= '0;
            res_match_q <= 1'b0;
            res_degen_q <= 1'b1;
            state_q     <= S_RES;
          end else begin
            dneg_q      <= dot[ACC_W-1];
            mul_x_q     <= PROD_W'({mag[ACC_W-2:0], 14'd0});
            mul_y_q     <= {mag[ACC_W-2:0], 14'd0};
            mul_start_q <= 1'b1;
            state_q     <= S_D2;
          end
        end
        S_D2: begin
          if (mul_done) begin
            d2_q        <= mul_p;
            mul_x_q     <= PROD_W'(na);
            mul_y_q     <= MAG_W'(nb);
            mul_start_q <= 1'b1;
            state_q     <= S_N;
          end
        end
        S_N: begin
          if (mul_done) begin
            n_q     <= mul_p;
            lo_q    <= '0;
            hi_q    <= HALF_U;
            state_q <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (lo_q >= hi_q) begin
            res_sim_q   <= sim_fin;
            res_match_q <= sim_fin >= thr_q;
            res_degen_q <= 1'b0;
            state_q     <= S_RES;
          end else begin
            mid_q       <= mid_sum[U_W:1];
            mul_x_q     <= PROD_W'(mid_sum[U_W:1]);
            mul_y_q     <= MAG_W'(mid_sum[U_W:1]);
            mul_start_q <= 1'b1;
            state_q     <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            mul_x_q     <= n_q;
            mul_y_q     <= MAG_W'(mul_p);
            mul_start_q <= 1'b1;
            state_q     <= S_CMP;
          end
        end
        S_CMP: begin
          if (mul_done) begin
            if (dneg_q) begin
              if (mul_p >= d2_q) hi_q <= mid_q;
              else               lo_q <= mid_q + U_W'(1);
            end else begin
              if (mul_p <= d2_q) lo_q <= mid_q;
              else               hi_q <= mid_q - U_W'(1);
            end
            state_q <= S_SRCH;
          end
        end
        S_RES: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_sim_q   <= res_sim_q;
            out_match_q <= res_match_q;
            out_degen_q <= res_degen_q;
            mac_clr_q   <= 1'b1;
            cnt_q       <= '0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // accumulators clear in the cycle after leaving the result state; input waits for it
  assign pipe_i.ready        = state_q == S_IDLE && !mac_clr_q;
  assign result_o.valid      = out_valid_q;
  assign result_o.similarity = out_sim_q;
  assign result_o.is_match   = out_match_q;
  assign result_o.degenerate = out_degen_q;
endmodule
